// ===== rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the 3d vector normalizer
// widths of the datapath, the core status group and the result bundle
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int VN_W    = 32;          // component, length and unit width
  localparam int SUM_W   = 2 * VN_W;    // sum of squares
  localparam int REM_W   = VN_W + 3;    // width of the shared compare-subtract
  localparam int ITER_W  = 5;           // iteration counter
  localparam int QUO_W   = VN_W - 1;    // quotient bits, result never exceeds 2^30

  typedef struct packed {
    logic idle;
    logic done;
  } vn_stat_t;

  typedef struct packed {
    logic [VN_W-1:0] unit_x;
    logic [VN_W-1:0] unit_y;
    logic [VN_W-1:0] unit_z;
    logic [VN_W-1:0] length;
    logic            zero_vector;
  } vn_result_t;

endpackage

// ===== rtl/vn_cmpsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_cmpsub: shared compare-subtract unit
// gives a - b and whether a >= b; serves both the root and the divide steps
// ----------------------------------------------------------------------------
module vn_cmpsub (
  input  logic [vn_pkg::REM_W-1:0] a,
  input  logic [vn_pkg::REM_W-1:0] b,
  output logic [vn_pkg::REM_W-1:0] diff,
  output logic                     ge
);
  import vn_pkg::*;

  logic [REM_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[REM_W-1:0];
  assign ge   = ~wide[REM_W];

endmodule

// ===== rtl/vn_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_core: sequencer and datapath of the normalizer
// squares through one multiplier, then a bit-by-bit integer square root and three
// restoring divisions, all stepping through the shared compare-subtract unit
// ----------------------------------------------------------------------------
module vn_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [vn_pkg::VN_W-1:0] start_x,
  input  logic [vn_pkg::VN_W-1:0] start_y,
  input  logic [vn_pkg::VN_W-1:0] start_z,
  input  logic                    take,
  output vn_pkg::vn_stat_t        stat,
  output vn_pkg::vn_result_t      result
);
  import vn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_DSET,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state;
  logic [VN_W-1:0]   mag_x, mag_y, mag_z;
  logic              neg_x, neg_y, neg_z;
  logic [1:0]        cnt;
  logic [1:0]        comp;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  prod;
  logic [VN_W:0]     rem;
  logic [VN_W-1:0]   root;
  logic [ITER_W-1:0] iter;
  logic [QUO_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [VN_W-1:0]   unit_x, unit_y, unit_z;
  logic              zero;

  logic [VN_W-1:0]   sq_sel;
  logic [VN_W-1:0]   dmag;
  logic              dneg;
  logic [REM_W-1:0]  root_rem_sh, root_trial;
  logic [REM_W-1:0]  div_rem_sh, div_trial;
  logic [REM_W-1:0]  cs_a, cs_b, cs_diff;
  logic              cs_ge;
  logic [QUO_W-1:0]  quo_next;
  logic [VN_W-1:0]   quo_ext, quo_signed;

  function automatic logic [VN_W-1:0] magnitude(input logic [VN_W-1:0] v);
    return v[VN_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    case (cnt)
      2'd0:    sq_sel = mag_x;
      2'd1:    sq_sel = mag_y;
      default: sq_sel = mag_z;
    endcase
    case (comp)
      2'd0: begin
        dmag = mag_x;
        dneg = neg_x;
      end
      2'd1: begin
        dmag = mag_y;
        dneg = neg_y;
      end
      default: begin
        dmag = mag_z;
        dneg = neg_z;
      end
    endcase
  end

  // root step brings down two radicand bits, trial is 4*root + 1
  assign root_rem_sh = {rem[VN_W:0], acc[SUM_W-1 -: 2]};
  assign root_trial  = {1'b0, root, 2'b01};
  // divide step brings down one dividend bit against the length
  assign div_rem_sh  = {2'b00, rem[VN_W-1:0], dsh[QUO_W-1]};
  assign div_trial   = {3'b000, root};

  assign cs_a = (state == S_ROOT) ? root_rem_sh : div_rem_sh;
  assign cs_b = (state == S_ROOT) ? root_trial  : div_trial;

  vn_cmpsub u_cmpsub (
    .a    (cs_a),
    .b    (cs_b),
    .diff (cs_diff),
    .ge   (cs_ge)
  );

  assign quo_next   = {quo[QUO_W-2:0], cs_ge};
  assign quo_ext    = {1'b0, quo_next};
  assign quo_signed = dneg ? (~quo_ext + 1'b1) : quo_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mag_x <= magnitude(start_x);
            mag_y <= magnitude(start_y);
            mag_z <= magnitude(start_z);
            neg_x <= start_x[VN_W-1];
            neg_y <= start_y[VN_W-1];
            neg_z <= start_z[VN_W-1];
            acc   <= '0;
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // product is registered, accumulation follows it in the next cycle
          prod <= {{VN_W{1'b0}}, sq_sel} * {{VN_W{1'b0}}, sq_sel};
          if (cnt != 2'd0) begin
            acc <= acc + prod;
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            rem   <= '0;
            root  <= '0;
            iter  <= '1;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (cs_ge) begin
            rem  <= cs_diff[VN_W:0];
            root <= {root[VN_W-2:0], 1'b1};
          end else begin
            rem  <= root_rem_sh[VN_W:0];
            root <= {root[VN_W-2:0], 1'b0};
          end
          acc  <= acc << 2;
          iter <= iter - 1'b1;
          if (iter == '0) begin
            comp  <= '0;
            state <= S_DSET;
          end
        end
        S_DSET: begin
          if (root == '0) begin
            unit_x <= '0;
            unit_y <= '0;
            unit_z <= '0;
            zero   <= 1'b1;
            state  <= S_DONE;
          end else begin
            // quotient stays below 2^31, so the top dividend bits start in rem
            zero  <= 1'b0;
            rem   <= {2'b00, dmag[VN_W-1:1]};
            dsh   <= {dmag[0], {(QUO_W-1){1'b0}}};
            quo   <= '0;
            iter  <= ITER_W'(QUO_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cs_ge) begin
            rem <= cs_diff[VN_W:0];
          end else begin
            rem <= div_rem_sh[VN_W:0];
          end
          quo  <= quo_next;
          dsh  <= dsh << 1;
          iter <= iter - 1'b1;
          if (iter == '0) begin
            case (comp)
              2'd0:    unit_x <= quo_signed;
              2'd1:    unit_y <= quo_signed;
              default: unit_z <= quo_signed;
            endcase
            if (comp == 2'd2) begin
              state <= S_DONE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DSET;
            end
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  assign result.unit_x      = unit_x;
  assign result.unit_y      = unit_y;
  assign result.unit_z      = unit_z;
  assign result.length      = zero ? '0 : root;
  assign result.zero_vector = zero;

endmodule

// ===== rtl/vector3_normalize.sv =====
`timescale 1ns / 1ps
// sequence: squares, square root, then three divisions; a zero vector skips the divisions
// a new item is taken only in the idle state, once the result has moved to the output
//   register; the root and divide steps all run through the single compare-subtract unit
// a finished result waits in the output register while the next item is taken
// reset: synchronous, active high; clears the sequencer and out_valid
// ----------------------------------------------------------------------------
// vector3_normalize: fixed point 3d vector normalizer
// gives the truncated euclidean length (q16.16) and the unit vector (q2.30)
// ----------------------------------------------------------------------------
module vector3_normalize (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [vn_pkg::VN_W-1:0] in_x,
  input  logic signed [vn_pkg::VN_W-1:0] in_y,
  input  logic signed [vn_pkg::VN_W-1:0] in_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [vn_pkg::VN_W-1:0] unit_x,
  output logic signed [vn_pkg::VN_W-1:0] unit_y,
  output logic signed [vn_pkg::VN_W-1:0] unit_z,
  output logic        [vn_pkg::VN_W-1:0] length,
  output logic                           zero_vector
);
  import vn_pkg::*;

  vn_stat_t   stat;
  vn_result_t result;
  logic       start;
  logic       take;

  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  // move the result out once the output register is free or draining
  assign take     = stat.done && (!out_valid || out_ready);

  vn_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .start_x (in_x),
    .start_y (in_y),
    .start_z (in_z),
    .take    (take),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      unit_x      <= result.unit_x;
      unit_y      <= result.unit_y;
      unit_z      <= result.unit_z;
      length      <= result.length;
      zero_vector <= result.zero_vector;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> unit_x == 0 && unit_y == 0 && unit_z == 0 && length == 0)
    else $error("zero vector result carries nonzero fields");

  a_nonzero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_vector |-> length != 0)
    else $error("nonzero vector with zero length");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_x <= 32'sd1073741824 && unit_x >= -32'sd1073741824 &&
                  unit_y <= 32'sd1073741824 && unit_y >= -32'sd1073741824 &&
                  unit_z <= 32'sd1073741824 && unit_z >= -32'sd1073741824)
    else $error("unit component outside of q2.30 unit range");
`endif

endmodule
